// File: design/bbd_pkg.sv
// Shared types and constants for the bilinear Bayer demosaic block.
package bbd_pkg;

    localparam int PIX_W     = 8;
    localparam int WORD_W    = 32;
    localparam int FW_W      = 10;
    localparam int FH_W      = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 10'd320;
    localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 12'd200;
    localparam logic [FH_W-1:0]  MIN_FRAME_DIM    = 12'd3;
    localparam logic [PIX_W-1:0] ALPHA_VALUE      = 8'hff;

    // control carried from the address stage to the window stage
    typedef struct packed {
        logic emit;
        logic last;
        logic x_odd;
        logic y_odd;
    } win_ctrl_t;

endpackage

// File: design/bayer_bilinear_demosaic_top.sv
// Bilinear 3x3 Bayer demosaic: raw Bayer bytes in, packed RGBA words out.
//
// Input channel s_*: one raw sample per request in raster order, tdata holds
// the sample and tuser marks the first sample of a frame. Output channel m_*:
// one RGBA word (alpha 0xff, red, green, blue) per interior pixel, tlast on the
// last interior pixel of the frame. Border rows and columns give no output, so
// a W x H frame yields (W-2) x (H-2) words.
// Frame size is set through the cfg_* write port while the block is idle;
// register 0 is the width, register 1 the height.
// An accepted sample is held in the address stage, and its result is loaded
// into the output register once that is free. Throughput: one sample per
// cycle unless m_* stalls, set by the one read per cycle of each line store.
// After reset the counters and window are cleared, the size is 320 x 200 and
// the line stores hold nothing useful until the first rows of a frame are in.
// When the receiver stalls, the output register holds its word, the window
// stage waits behind it and s_tready drops once both are full.
module bayer_bilinear_demosaic_top #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bbd_pkg::PIX_W-1:0]          s_tdata,   // [7:0] raw_pixel
    input  logic [0:0]                         s_tuser,   // [0] frame_start
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bbd_pkg::WORD_W-1:0]         m_tdata,   // [31:0] pixel_word
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [bbd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bbd_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int EW     = (COL_W > bbd_pkg::FW_W) ? COL_W : bbd_pkg::FW_W;
    localparam int PW     = bbd_pkg::PIX_W;
    localparam int RW     = bbd_pkg::FH_W;

    logic [bbd_pkg::FW_W-1:0] frame_width_reg;
    logic [RW-1:0]            frame_height_reg;
    logic [COL_W-1:0]         col_reg, col_next;
    logic [RW-1:0]            row_reg, row_next;

    logic                     s1_valid_reg;
    bbd_pkg::win_ctrl_t       s1_ctl_reg, s1_ctl_next;
    logic [ADDR_W-1:0]        s1_addr_reg, s1_addr_next;
    logic [PW-1:0]            s1_pix_reg;

    logic [PW-1:0]            upper_mem [MAX_WIDTH];
    logic [PW-1:0]            middle_mem [MAX_WIDTH];
    logic [PW-1:0]            upper_rd_reg, middle_rd_reg;
    logic [PW-1:0]            win_reg [6];

    logic                     m_tvalid_reg;
    logic [bbd_pkg::WORD_W-1:0] m_tdata_reg, m_tdata_next;
    logic                     m_tlast_reg;

    logic                     s_accept, advance, s1_fire;
    logic [EW-1:0]            fw_ext, eff_w;
    logic [RW-1:0]            eff_h;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && advance;
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        fw_ext = EW'(frame_width_reg);
        if (fw_ext < EW'(3)) begin
            eff_w = EW'(3);
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = fw_ext;
        end
        eff_h = (frame_height_reg < bbd_pkg::MIN_FRAME_DIM) ? bbd_pkg::MIN_FRAME_DIM
                                                            : frame_height_reg;
    end

    // address stage: position of this sample and counts for the next one
    logic [COL_W-1:0] col_a, col_c;
    logic [RW-1:0]    row_a, row_c;

    always_comb begin
        col_a = s_tuser[0] ? '0 : col_reg;
        row_a = s_tuser[0] ? '0 : row_reg;
        if (EW'(col_a) >= eff_w) begin
            col_c = '0;
            row_c = row_a + RW'(1);
        end else begin
            col_c = col_a;
            row_c = row_a;
        end
        if (row_c >= eff_h) begin
            row_c = '0;
        end

        col_next = col_c + COL_W'(1);
        row_next = row_c;
        if (EW'(col_next) >= eff_w) begin
            col_next = '0;
            row_next = row_c + RW'(1);
        end
        if (row_next >= eff_h) begin
            row_next = '0;
        end

        s1_addr_next      = col_c[ADDR_W-1:0];
        s1_ctl_next.emit  = (col_c >= COL_W'(2)) && (row_c >= RW'(2));
        s1_ctl_next.last  = (EW'(col_c) == eff_w - EW'(1)) && (row_c == eff_h - RW'(1));
        s1_ctl_next.x_odd = ~col_c[0];
        s1_ctl_next.y_odd = ~row_c[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= bbd_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bbd_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                bbd_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[bbd_pkg::FW_W-1:0];
                bbd_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_ctl_reg    <= s1_ctl_next;
            s1_addr_reg   <= s1_addr_next;
            s1_pix_reg    <= s_tdata;
            upper_rd_reg  <= upper_mem[s1_addr_next];
            middle_rd_reg <= middle_mem[s1_addr_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            upper_mem[s1_addr_reg]  <= middle_rd_reg;
            middle_mem[s1_addr_reg] <= s1_pix_reg;
        end
    end

    // window stage: tl/ml/bl in win 0..2, tm/mm/bm in win 3..5
    logic [PW+1:0] cross_sum, diag_sum;
    logic [PW:0]   horz_sum, vert_sum;
    logic [PW-1:0] cross_avg, diag_avg, horz_avg, vert_avg;
    logic [PW-1:0] red, grn, blu;

    always_comb begin
        cross_sum = (PW+2)'(win_reg[1]) + (PW+2)'(middle_rd_reg)
                  + (PW+2)'(win_reg[3]) + (PW+2)'(win_reg[5]);
        diag_sum  = (PW+2)'(win_reg[0]) + (PW+2)'(upper_rd_reg)
                  + (PW+2)'(win_reg[2]) + (PW+2)'(s1_pix_reg);
        horz_sum  = (PW+1)'(win_reg[1]) + (PW+1)'(middle_rd_reg);
        vert_sum  = (PW+1)'(win_reg[3]) + (PW+1)'(win_reg[5]);
        cross_avg = cross_sum[PW+1:2];
        diag_avg  = diag_sum[PW+1:2];
        horz_avg  = horz_sum[PW:1];
        vert_avg  = vert_sum[PW:1];
        case ({s1_ctl_reg.y_odd, s1_ctl_reg.x_odd})
            2'b11: begin
                red = win_reg[4]; grn = cross_avg; blu = diag_avg;
            end
            2'b10: begin
                red = horz_avg; grn = win_reg[4]; blu = vert_avg;
            end
            2'b01: begin
                red = vert_avg; grn = win_reg[4]; blu = horz_avg;
            end
            default: begin
                red = diag_avg; grn = cross_avg; blu = win_reg[4];
            end
        endcase
        m_tdata_next = {bbd_pkg::ALPHA_VALUE, red, grn, blu};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_fire) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= upper_rd_reg;
            win_reg[4] <= middle_rd_reg;
            win_reg[5] <= s1_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= s1_valid_reg && s1_ctl_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_ctl_reg.emit) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= s1_ctl_reg.last;
        end
    end

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && m_tvalid_reg && !m_tready))
        else $error("input blocked while pipeline has room");

    a_emit_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_ctl_reg.emit) |=> m_tvalid_reg)
        else $error("window result not loaded into output register");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        EW'(col_reg) <= EW'(MAX_WIDTH))
        else $error("column count beyond line store");

endmodule

// File: tb/bayer_bilinear_demosaic_top_tb.sv
// Self-checking testbench for bayer_bilinear_demosaic_top: directed and random frames.
module bayer_bilinear_demosaic_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W      = 512;
    localparam int HANG_LIMIT = 5000;
    localparam int RANDOM_SAMPLES = 280;

    typedef struct packed {
        logic [bbd_pkg::WORD_W-1:0] word;
        logic                       last;
    } rgba_t;

    typedef struct packed {
        logic [bbd_pkg::PIX_W-1:0]  pix;
        logic                       sof;
        logic                       gives;
        logic [bbd_pkg::WORD_W-1:0] word;
        logic                       last;
    } sample_row_t;

    typedef enum int {FILL_ANY, FILL_RAILS, FILL_FLAT} fill_t;
    typedef enum int {PHASE_FRAMES, PHASE_ABORT, PHASE_RESIZE, PHASE_NOISE} phase_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [bbd_pkg::PIX_W-1:0]     s_tdata   = '0;
    logic [0:0]                    s_tuser   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [bbd_pkg::WORD_W-1:0]    m_tdata;
    logic                          m_tlast;
    logic                          cfg_we    = 1'b0;
    logic [bbd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bbd_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

    // predictor state
    logic [bbd_pkg::FW_W-1:0]  width_reg;
    logic [bbd_pkg::FH_W-1:0]  height_reg;
    logic [bbd_pkg::PIX_W-1:0] line_up [MAX_W];
    logic [bbd_pkg::PIX_W-1:0] line_mid [MAX_W];
    logic [bbd_pkg::PIX_W-1:0] win_left [3];
    logic [bbd_pkg::PIX_W-1:0] win_mid [3];
    int unsigned               col_pos;
    int unsigned               row_pos;

    rgba_t rgba_due[$];
    int    fail_count   = 0;
    int    samples_sent = 0;
    int    quiet_cycles = 0;
    int    stall_left   = 0;
    bit    calm         = 1'b0;

    // 3x3 frames: all-ones, a cut-off start, then all-zeros after a mid-frame restart
    sample_row_t opening_rows [20] = '{
        '{8'hff, 1'b1, 1'b0, 32'h0, 1'b0},
        '{8'hff, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'hff, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'hff, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'hff, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'hff, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'hff, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'hff, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'hff, 1'b0, 1'b1, 32'hffffffff, 1'b1},
        '{8'h5a, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'ha5, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h00, 1'b1, 1'b0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b0, 32'h0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 32'hff000000, 1'b1}
    };

    bayer_bilinear_demosaic_top #(
        .MAX_WIDTH(MAX_W)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    function automatic int unsigned eff_width();
        if (width_reg < 3) return 3;
        if (width_reg > MAX_W) return MAX_W;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg < 3) return 3;
        return 32'(height_reg);
    endfunction

    function automatic void wrap_pos(input int unsigned w, input int unsigned h);
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
    endfunction

    function automatic bit predict_rgba(input logic [bbd_pkg::PIX_W-1:0] pix, input logic sof,
                                        output rgba_t res);
        int unsigned w, h, c, r;
        logic [bbd_pkg::PIX_W-1:0] tl, ml, bl, tm, mm, bm, tr, mr;
        logic [bbd_pkg::PIX_W+1:0] quad_x, quad_d;
        logic [bbd_pkg::PIX_W:0]   pair_h, pair_v;
        logic [bbd_pkg::PIX_W-1:0] red, grn, blu;
        bit fire;
        w = eff_width();
        h = eff_height();
        if (sof) begin
            col_pos = 0;
            row_pos = 0;
        end
        wrap_pos(w, h);
        c = col_pos;
        r = row_pos;
        tl = win_left[0]; ml = win_left[1]; bl = win_left[2];
        tm = win_mid[0];  mm = win_mid[1];  bm = win_mid[2];
        tr = line_up[c];
        mr = line_mid[c];
        quad_x = (bbd_pkg::PIX_W+2)'(ml) + (bbd_pkg::PIX_W+2)'(mr)
               + (bbd_pkg::PIX_W+2)'(tm) + (bbd_pkg::PIX_W+2)'(bm);
        quad_d = (bbd_pkg::PIX_W+2)'(tl) + (bbd_pkg::PIX_W+2)'(tr)
               + (bbd_pkg::PIX_W+2)'(bl) + (bbd_pkg::PIX_W+2)'(pix);
        pair_h = (bbd_pkg::PIX_W+1)'(ml) + (bbd_pkg::PIX_W+1)'(mr);
        pair_v = (bbd_pkg::PIX_W+1)'(tm) + (bbd_pkg::PIX_W+1)'(bm);
        fire = (c >= 2) && (r >= 2);
        res = '0;
        if (fire) begin
            // centre is (c-1, r-1): odd centre row means even r
            if (r % 2 == 0) begin
                if (c % 2 == 0) begin
                    red = mm;
                    grn = quad_x[bbd_pkg::PIX_W+1:2];
                    blu = quad_d[bbd_pkg::PIX_W+1:2];
                end else begin
                    red = pair_h[bbd_pkg::PIX_W:1]; grn = mm; blu = pair_v[bbd_pkg::PIX_W:1];
                end
            end else begin
                if (c % 2 == 0) begin
                    red = pair_v[bbd_pkg::PIX_W:1]; grn = mm; blu = pair_h[bbd_pkg::PIX_W:1];
                end else begin
                    red = quad_d[bbd_pkg::PIX_W+1:2];
                    grn = quad_x[bbd_pkg::PIX_W+1:2];
                    blu = mm;
                end
            end
            res.word = {bbd_pkg::ALPHA_VALUE, red, grn, blu};
            res.last = (c == w - 1) && (r == h - 1);
        end
        win_left[0] = tm; win_left[1] = mm; win_left[2] = bm;
        win_mid[0]  = tr; win_mid[1]  = mr; win_mid[2]  = pix;
        line_up[c]  = mr;
        line_mid[c] = pix;
        col_pos = c + 1;
        wrap_pos(w, h);
        return fire;
    endfunction

    function automatic int idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [bbd_pkg::PIX_W-1:0] pick_pixel(input fill_t fill);
        case (fill)
            FILL_RAILS: return $urandom_range(0, 1) ? 8'hff : 8'h00;
            FILL_FLAT:  return 8'($urandom_range(120, 135));
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [bbd_pkg::CFG_DAT_W-1:0] pick_width_cfg();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 12'($urandom_range(0, 2));
        if (roll == 1) return 12'($urandom_range(17, 40));
        if (roll == 2) return 12'hc00 | 12'($urandom_range(3, 12));   // bits above the field
        return 12'($urandom_range(3, 12));
    endfunction

    function automatic logic [bbd_pkg::CFG_DAT_W-1:0] pick_height_cfg();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 12'($urandom_range(0, 2));
        if (roll == 1) return 12'($urandom_range(9, 16));
        return 12'($urandom_range(3, 7));
    endfunction

    task automatic set_frame(input logic [bbd_pkg::CFG_DAT_W-1:0] wv,
                             input logic [bbd_pkg::CFG_DAT_W-1:0] hv);
        cfg_we    <= 1'b1;
        cfg_index <= bbd_pkg::CFG_FRAME_WIDTH;
        cfg_wdata <= wv;
        @(posedge aclk);
        cfg_index <= bbd_pkg::CFG_FRAME_HEIGHT;
        cfg_wdata <= hv;
        @(posedge aclk);
        cfg_we <= 1'b0;
        width_reg  = wv[bbd_pkg::FW_W-1:0];
        height_reg = hv;
    endtask

    task automatic send_sample(input logic [bbd_pkg::PIX_W-1:0] pix, input logic sof,
                               input bit typed, input bit t_gives, input rgba_t t_res);
        int gap;
        rgba_t res;
        bit fire;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= pix;
        s_tuser[0] <= sof;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        fire = predict_rgba(pix, sof, res);
        if (typed) begin
            if (t_gives) rgba_due.push_back(t_res);
        end else if (fire) begin
            rgba_due.push_back(res);
        end
    endtask

    task automatic feed(input int count, input bit sof_first, input fill_t fill);
        for (int i = 0; i < count; i++)
            send_sample(pick_pixel(fill), sof_first && (i == 0), 1'b0, 1'b0, '0);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (rgba_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_out
        rgba_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (rgba_due.size() == 0) begin
                $error("unexpected result: pixel_word %h last_in_frame %b", m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = rgba_due.pop_front();
                if (m_tdata !== want.word) begin
                    $error("pixel_word: expected %h, got %h", want.word, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_in_frame: expected %b, got %b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("bayer_bilinear_demosaic_top_tb failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned ew, eh, w2, h2, c2, r2, lo, stop_at;
        phase_t phase;
        fill_t fill;
        rgba_t due;
        int roll;

        width_reg  = bbd_pkg::FRAME_WIDTH_RST;
        height_reg = bbd_pkg::FRAME_HEIGHT_RST;
        foreach (line_up[i]) begin
            line_up[i]  = '0;
            line_mid[i] = '0;
        end
        foreach (win_left[i]) begin
            win_left[i] = '0;
            win_mid[i]  = '0;
        end
        col_pos = 0;
        row_pos = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // both sizes below the minimum act as 3 x 3
        set_frame(12'd0, 12'd0);
        foreach (opening_rows[i]) begin
            due.word = opening_rows[i].word;
            due.last = opening_rows[i].last;
            send_sample(opening_rows[i].pix, opening_rows[i].sof, 1'b1,
                        opening_rows[i].gives, due);
        end
        settle();

        // width above the maximum clamps to a full line store; two full rows, then the start of row 2
        set_frame(12'hfff, 12'd3);
        feed(MAX_W * 2 + 16, 1'b1, FILL_ANY);
        settle();

        // tallest frame, only its top rows
        set_frame(12'd3, 12'hfff);
        feed(60, 1'b1, FILL_ANY);
        settle();

        stop_at = samples_sent + RANDOM_SAMPLES;
        while (samples_sent < stop_at) begin
            calm = ($urandom_range(0, 3) == 0);
            fill = ($urandom_range(0, 4) < 3) ? FILL_ANY : fill_t'($urandom_range(1, 2));
            roll = $urandom_range(0, 99);
            if (roll < 55) phase = PHASE_FRAMES;
            else if (roll < 70) phase = PHASE_ABORT;
            else if (roll < 88) phase = PHASE_RESIZE;
            else phase = PHASE_NOISE;

            case (phase)
                PHASE_FRAMES: begin
                    set_frame(pick_width_cfg(), pick_height_cfg());
                    ew = eff_width();
                    eh = eff_height();
                    repeat ($urandom_range(1, 3))
                        feed(ew * eh, 1'($urandom_range(0, 1)), fill);
                end
                PHASE_ABORT: begin
                    set_frame(pick_width_cfg(), pick_height_cfg());
                    ew = eff_width();
                    eh = eff_height();
                    feed($urandom_range(1, ew * eh - 1), 1'b1, fill);
                    feed(ew * eh, 1'b1, fill);
                end
                PHASE_RESIZE: begin
                    set_frame(12'($urandom_range(4, 14)), 12'($urandom_range(4, 9)));
                    ew = eff_width();
                    eh = eff_height();
                    feed($urandom_range(1, ew * eh - 1), 1'b1, fill);
                    settle();
                    // shrink only; a row wrap must land on column zero
                    w2 = $urandom_range(3, ew);
                    c2 = (col_pos >= w2) ? 0 : col_pos;
                    r2 = (col_pos >= w2) ? row_pos + 1 : row_pos;
                    lo = (c2 != 0 && r2 + 1 > 3) ? r2 + 1 : 3;
                    h2 = $urandom_range(lo, eh);
                    set_frame(12'(w2), 12'(h2));
                    feed($urandom_range(1, 2 * w2 * h2), 1'b0, fill);
                end
                default: begin
                    send_sample(pick_pixel(fill), 1'b1, 1'b0, 1'b0, '0);
                    repeat ($urandom_range(5, 30))
                        send_sample(pick_pixel(fill), $urandom_range(0, 3) == 0, 1'b0, 1'b0, '0);
                end
            endcase
            settle();
        end

        calm = 1'b0;
        settle();
        if (fail_count == 0) begin
            $display("bayer_bilinear_demosaic_top_tb passed");
        end else begin
            $display("bayer_bilinear_demosaic_top_tb failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/bbd_pkg.sv
design/bayer_bilinear_demosaic_top.sv
tb/bayer_bilinear_demosaic_top_tb.sv
